// ===== design/cab_pkg.sv =====
// Shared types and arithmetic helpers for the coverage alpha blend pipeline.
package cab_pkg;

    localparam int unsigned PixelWidth = 32;
    localparam int unsigned ChanWidth  = 8;
    localparam int unsigned SumWidth   = 17;

    localparam logic [ChanWidth-1:0] ChanMax  = 8'hFF;
    localparam logic [SumWidth-1:0]  RoundAdd = 17'd127;

    typedef struct packed {
        logic [PixelWidth-1:0] existing_pixel;
        logic [ChanWidth-1:0]  coverage;
    } pixel_in_t;

    typedef struct packed {
        logic [PixelWidth-1:0] result_pixel;
        logic                  written;
    } pixel_out_t;

    // Item between the alpha scaling half and the channel mixing half.
    typedef struct packed {
        logic [PixelWidth-1:0] existing_pixel;
        logic [ChanWidth-1:0]  scaled;
        logic                  written;
        logic                  opaque;
    } scaled_item_t;

    // Rounded-sum quotient by 255, exact for sums below 65280.
    function automatic logic [ChanWidth-1:0] div255(input logic [SumWidth-1:0] x);
        logic [SumWidth:0] t;
        t = {1'b0, x} + {9'd0, x[SumWidth-1:8]} + 18'd1;
        return t[15:8];
    endfunction

endpackage

// ===== design/cab_scale.sv =====
// Two pipeline stages: coverage times fill alpha, then rounded divide by 255.
module cab_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           fill_alpha,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  cab_pkg::pixel_in_t   src_data,
    output logic                 mid_valid,
    input  logic                 mid_stall,
    output cab_pkg::scaled_item_t mid_data
);
    import cab_pkg::*;

    logic                  s1_valid_reg;
    logic [SumWidth-1:0]   s1_prod_reg;
    logic                  s1_pass_reg;
    logic [PixelWidth-1:0] s1_pixel_reg;
    logic                  s2_valid_reg;
    scaled_item_t          s2_item_reg;
    logic                  s1_en;
    logic                  s2_en;
    logic [SumWidth-1:0]   s1_prod_next;
    scaled_item_t          s2_item_next;

    // A stage moves when it is empty or its successor moves.
    assign s2_en     = !s2_valid_reg || !mid_stall;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign src_stall = !s1_en;

    assign s1_prod_next = SumWidth'(fill_alpha) * SumWidth'(src_data.coverage) + RoundAdd;

    always_comb
    begin
        s2_item_next.existing_pixel = s1_pixel_reg;
        s2_item_next.scaled         = div255(s1_prod_reg);
        s2_item_next.written        = !s1_pass_reg && (s2_item_next.scaled != '0);
        s2_item_next.opaque         = (s2_item_next.scaled == ChanMax);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= src_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && src_valid)
        begin
            s1_prod_reg  <= s1_prod_next;
            s1_pass_reg  <= (fill_alpha == '0) || (src_data.coverage == '0);
            s1_pixel_reg <= src_data.existing_pixel;
        end
        if (s2_en && s1_valid_reg)
            s2_item_reg <= s2_item_next;
    end

    assign mid_valid = s2_valid_reg;
    assign mid_data  = s2_item_reg;

endmodule

// ===== design/cab_mix.sv =====
// Two pipeline stages: per-channel source-over products, then divide and pack.
module cab_mix (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [23:0]           fill_rgb,
    input  logic                  mid_valid,
    output logic                  mid_stall,
    input  cab_pkg::scaled_item_t mid_data,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    output cab_pkg::pixel_out_t   dst_data
);
    import cab_pkg::*;

    logic                  s3_valid_reg;
    scaled_item_t          s3_item_reg;
    logic [SumWidth-1:0]   s3_sum_reg [4];
    logic                  s4_valid_reg;
    pixel_out_t            s4_out_reg;
    logic                  s3_en;
    logic                  s4_en;
    logic [ChanWidth-1:0]  inv;
    logic [SumWidth-1:0]   s3_sum_next [4];
    pixel_out_t            s4_out_next;
    logic [ChanWidth:0]    alpha_wide;
    logic [ChanWidth-1:0]  alpha_sat;

    assign s4_en     = !s4_valid_reg || !dst_stall;
    assign s3_en     = !s3_valid_reg || s4_en;
    assign mid_stall = !s3_en;

    assign inv = ChanMax - mid_data.scaled;

    // Index 3 holds the destination alpha term, 2..0 hold R, G, B.
    always_comb
    begin
        s3_sum_next[3] = SumWidth'(mid_data.existing_pixel[31:24]) * SumWidth'(inv)
                       + RoundAdd;
        for (int i = 0; i < 3; i++)
        begin
            s3_sum_next[i] = SumWidth'(fill_rgb[i*8 +: 8]) * SumWidth'(mid_data.scaled)
                           + SumWidth'(mid_data.existing_pixel[i*8 +: 8]) * SumWidth'(inv)
                           + RoundAdd;
        end
    end

    assign alpha_wide = {1'b0, s3_item_reg.scaled} + {1'b0, div255(s3_sum_reg[3])};
    assign alpha_sat  = alpha_wide[ChanWidth] ? ChanMax : alpha_wide[ChanWidth-1:0];

    always_comb
    begin
        s4_out_next.written = s3_item_reg.written;
        if (!s3_item_reg.written)
            s4_out_next.result_pixel = s3_item_reg.existing_pixel;
        else if (s3_item_reg.opaque)
            s4_out_next.result_pixel = {ChanMax, fill_rgb};
        else
            s4_out_next.result_pixel = {alpha_sat, div255(s3_sum_reg[2]),
                                        div255(s3_sum_reg[1]), div255(s3_sum_reg[0])};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_en)
                s3_valid_reg <= mid_valid;
            if (s4_en)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && mid_valid)
        begin
            s3_item_reg <= mid_data;
            for (int i = 0; i < 4; i++)
                s3_sum_reg[i] <= s3_sum_next[i];
        end
        if (s4_en && s3_valid_reg)
            s4_out_reg <= s4_out_next;
    end

    assign dst_valid = s4_valid_reg;
    assign dst_data  = s4_out_reg;

endmodule

// ===== design/coverage_alpha_blend_span.sv =====
// Throughput: one pixel per cycle while dst is not stalled; four register
// stages (alpha multiply, alpha divide, channel multiply-add, channel divide
// and pack) each move independently, so a stall on dst fills bubbles
// before src is stalled.
// Reset clears all stage valid bits and the fill color to 0.
module coverage_alpha_blend_span (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data,
    input  logic                src_valid,
    output logic                src_stall,
    input  cab_pkg::pixel_in_t  src_data,
    output logic                dst_valid,
    input  logic                dst_stall,
    output cab_pkg::pixel_out_t dst_data
);
    import cab_pkg::*;

    logic [PixelWidth-1:0] fill_color_reg;
    logic                  mid_valid;
    logic                  mid_stall;
    scaled_item_t          mid_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_color_reg <= '0;
        else if (cfg_valid && cfg_ready)
            fill_color_reg <= cfg_data;
    end

    cab_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .fill_alpha (fill_color_reg[31:24]),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .mid_valid  (mid_valid),
        .mid_stall  (mid_stall),
        .mid_data   (mid_data)
    );

    cab_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .fill_rgb  (fill_color_reg[23:0]),
        .mid_valid (mid_valid),
        .mid_stall (mid_stall),
        .mid_data  (mid_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

endmodule
